FILE: rtl/sip_header_line_framer_defines.svh
// sip_header_line_framer_defines.svh: assertion macros for the sip header line framer
// needs clk and rst_n in the scope where the macros are used
`ifndef SIP_HEADER_LINE_FRAMER_DEFINES_SVH
`define SIP_HEADER_LINE_FRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHLF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHLF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/shlf_pkg.sv
// shlf_pkg.sv: types, codes and constants of the sip header line framer
// no dependencies; used by every module of the block
package shlf_pkg;

    // parameter defaults
    localparam int MAX_BYTES_DEFAULT = 4096;
    localparam int HDR_LIMIT_DEFAULT = 255;

    // character codes
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QUEUE_AW + 1;

    typedef enum logic [2:0] {
        KIND_START      = 3'd0,
        KIND_HEADER     = 3'd1,
        KIND_END        = 3'd2,
        KIND_BAD_START  = 3'd3,
        KIND_NO_HEADERS = 3'd4,
        KIND_TRUNCATED  = 3'd5,
        KIND_TOO_LONG   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_HEADERS,
        PH_BODY,
        PH_STOPPED
    } phase_t;

    typedef logic [11:0] line_t;
    typedef logic [7:0]  index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } item_t;

    typedef struct packed {
        kind_t  result_kind;
        line_t  line_offset;
        line_t  line_length;
        index_t header_index;
        logic   last_of_run;
    } result_t;

    // results produced by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

FILE: rtl/sip_header_line_framer.sv
// sip_header_line_framer: frames start line and headers of a sip message, one byte a cycle while the queue has room.
// Path: a byte is held in the input register, and its results are written to the queue before they are offered.
// Throughput: one byte per cycle while the queue has room; a byte that yields two results is read out one at a time
// through the single read port of the four-entry result queue.
// Reset: rst_n clears framing state and empties the queue; no clearing pass is needed.
// Depends on shlf_pkg, shlf_step, shlf_queue and sip_header_line_framer_defines.svh.
`include "sip_header_line_framer_defines.svh"

module sip_header_line_framer #(
    parameter int MAX_MESSAGE_BYTES  = shlf_pkg::MAX_BYTES_DEFAULT,
    parameter int HEADER_COUNT_LIMIT = shlf_pkg::HDR_LIMIT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  shlf_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output shlf_pkg::result_t result
);

    shlf_pkg::push_t push;
    logic            room;

    // byte framing
    shlf_step #(
        .MAX_MESSAGE_BYTES  (MAX_MESSAGE_BYTES),
        .HEADER_COUNT_LIMIT (HEADER_COUNT_LIMIT)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .room       (room),
        .push       (push)
    );

    // result buffering
    shlf_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // checks
    `SHLF_ASSERT_IMP(a_stall_has_result, !item_ready, result_valid, "input stalled with empty queue")
    `SHLF_ASSERT_NXT(a_run_continues, result_valid && result_ready && !result.last_of_run, result_valid, "second result of a run missing")
    `SHLF_ASSERT_IMP(a_trunc_ends_run, result_valid && result.result_kind == shlf_pkg::KIND_TRUNCATED, result.last_of_run, "truncation not last of run")

endmodule

FILE: rtl/shlf_step.sv
// shlf_step.sv: input register, framing state and per-byte line logic
// depends on shlf_pkg; feeds results to shlf_queue
module shlf_step #(
    parameter int MAX_MESSAGE_BYTES  = shlf_pkg::MAX_BYTES_DEFAULT,
    parameter int HEADER_COUNT_LIMIT = shlf_pkg::HDR_LIMIT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  shlf_pkg::item_t   item,
    input  logic              room,
    output shlf_pkg::push_t   push
);

    localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int CNT_W = $clog2(HEADER_COUNT_LIMIT + 1);
    localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_MESSAGE_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(HEADER_COUNT_LIMIT);
    localparam logic [OFF_W-1:0] OFF_ONE = OFF_W'(1);

    logic              stage_valid_reg;
    shlf_pkg::item_t   stage_reg;
    logic              fire;

    shlf_pkg::phase_t  phase_reg, phase_next;
    logic              prev_cr_reg, prev_cr_next;
    logic              line_begin_reg, line_begin_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [OFF_W-1:0]  line_start_reg, line_start_next;
    logic [OFF_W-1:0]  pend_start_reg, pend_start_next;
    logic [OFF_W-1:0]  pend_len_reg, pend_len_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;

    logic [7:0]        cur_byte;
    logic [OFF_W-1:0]  off_plus1;
    logic [OFF_W-1:0]  eol_len;
    logic [OFF_W-1:0]  pend_span;
    logic              active;
    logic              hdr_emit;
    logic              line_emit;
    shlf_pkg::kind_t   line_kind;
    logic [OFF_W-1:0]  line_off;
    logic [OFF_W-1:0]  line_len;
    logic [CNT_W-1:0]  seen_upd;
    logic              trunc_emit;
    logic [OFF_W-1:0]  trunc_off;
    logic [OFF_W-1:0]  trunc_len;
    shlf_pkg::result_t hdr_res, line_res, trunc_res;

    // header count as reported, capped at 255
    function automatic shlf_pkg::index_t sat_index(input logic [CNT_W-1:0] c);
        return (32'(c) > 32'd255) ? shlf_pkg::index_t'(8'hFF) : shlf_pkg::index_t'(c);
    endfunction

    // one byte sits in the input register until the queue has room for two results
    assign fire       = stage_valid_reg && room;
    assign item_ready = !stage_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            stage_reg <= item;
        end
    end

    // line framing for the byte in the input register
    always_comb
    begin
        cur_byte        = stage_reg.data_byte;
        off_plus1       = offset_reg + OFF_ONE;
        eol_len         = offset_reg - OFF_ONE - line_start_reg;
        pend_span       = offset_reg - OFF_ONE - pend_start_reg;
        active          = (phase_reg == shlf_pkg::PH_START) ||
                          (phase_reg == shlf_pkg::PH_HEADERS);

        phase_next      = phase_reg;
        prev_cr_next    = prev_cr_reg;
        line_begin_next = line_begin_reg;
        offset_next     = offset_reg;
        line_start_next = line_start_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        pend_valid_next = pend_valid_reg;
        seen_next       = seen_reg;

        hdr_emit        = 1'b0;
        line_emit       = 1'b0;
        line_kind       = shlf_pkg::KIND_START;
        line_off        = line_start_reg;
        line_len        = '0;
        trunc_emit      = 1'b0;

        if (active)
        begin
            if (offset_reg >= OFF_MAX)
            begin
                // oversize message
                line_emit  = 1'b1;
                line_kind  = shlf_pkg::KIND_TOO_LONG;
                phase_next = shlf_pkg::PH_STOPPED;
            end
            else
            begin
                offset_next = off_plus1;

                // a non-folding first byte releases the held header
                if (phase_reg == shlf_pkg::PH_HEADERS && line_begin_reg && pend_valid_reg &&
                    cur_byte != shlf_pkg::CHAR_SP && cur_byte != shlf_pkg::CHAR_TAB)
                begin
                    hdr_emit        = 1'b1;
                    pend_valid_next = 1'b0;
                    if (seen_reg < CNT_MAX)
                    begin
                        seen_next = seen_reg + CNT_W'(1);
                    end
                end
                line_begin_next = 1'b0;

                // cr lf closes the current line
                if (prev_cr_reg && cur_byte == shlf_pkg::CHAR_LF)
                begin
                    if (phase_reg == shlf_pkg::PH_START)
                    begin
                        line_emit = 1'b1;
                        if (eol_len == '0)
                        begin
                            line_kind  = shlf_pkg::KIND_BAD_START;
                            phase_next = shlf_pkg::PH_STOPPED;
                        end
                        else
                        begin
                            line_kind  = shlf_pkg::KIND_START;
                            line_len   = eol_len;
                            phase_next = shlf_pkg::PH_HEADERS;
                        end
                    end
                    else if (eol_len == '0)
                    begin
                        line_emit = 1'b1;
                        if (seen_next == '0)
                        begin
                            line_kind  = shlf_pkg::KIND_NO_HEADERS;
                            phase_next = shlf_pkg::PH_STOPPED;
                        end
                        else
                        begin
                            line_kind  = shlf_pkg::KIND_END;
                            line_off   = off_plus1;
                            phase_next = shlf_pkg::PH_BODY;
                        end
                    end
                    else if (pend_valid_next)
                    begin
                        pend_len_next = pend_span;
                    end
                    else
                    begin
                        pend_start_next = line_start_reg;
                        pend_len_next   = eol_len;
                        pend_valid_next = 1'b1;
                    end
                    line_start_next = off_plus1;
                    line_begin_next = 1'b1;
                    prev_cr_next    = 1'b0;
                end
                else
                begin
                    prev_cr_next = (cur_byte == shlf_pkg::CHAR_CR);
                end
            end

            if (stage_reg.is_last && (phase_next == shlf_pkg::PH_START ||
                                      phase_next == shlf_pkg::PH_HEADERS))
            begin
                trunc_emit = 1'b1;
            end
        end

        seen_upd  = seen_next;
        trunc_off = line_start_next;
        trunc_len = offset_next - line_start_next;

        // end of message returns to the reset state
        if (stage_reg.is_last)
        begin
            phase_next      = shlf_pkg::PH_START;
            prev_cr_next    = 1'b0;
            line_begin_next = 1'b1;
            offset_next     = '0;
            line_start_next = '0;
            pend_start_next = '0;
            pend_len_next   = '0;
            pend_valid_next = 1'b0;
            seen_next       = '0;
        end
    end

    // result records
    always_comb
    begin
        hdr_res.result_kind    = shlf_pkg::KIND_HEADER;
        hdr_res.line_offset    = shlf_pkg::line_t'(pend_start_reg);
        hdr_res.line_length    = shlf_pkg::line_t'(pend_len_reg);
        hdr_res.header_index   = sat_index(seen_reg);
        hdr_res.last_of_run    = !trunc_emit;

        line_res.result_kind   = line_kind;
        line_res.line_offset   = shlf_pkg::line_t'(line_off);
        line_res.line_length   = shlf_pkg::line_t'(line_len);
        line_res.header_index  = sat_index(seen_upd);
        line_res.last_of_run   = !trunc_emit;

        trunc_res.result_kind  = shlf_pkg::KIND_TRUNCATED;
        trunc_res.line_offset  = shlf_pkg::line_t'(trunc_off);
        trunc_res.line_length  = shlf_pkg::line_t'(trunc_len);
        trunc_res.header_index = sat_index(seen_upd);
        trunc_res.last_of_run  = 1'b1;

        // a header release and a line result never come from the same byte
        push.second = trunc_res;
        if (hdr_emit)
        begin
            push.first = hdr_res;
        end
        else if (line_emit)
        begin
            push.first = line_res;
        end
        else
        begin
            push.first = trunc_res;
        end

        if (!fire)
        begin
            push.count = 2'd0;
        end
        else
        begin
            push.count = 2'((hdr_emit || line_emit) ? 1 : 0) + 2'(trunc_emit ? 1 : 0);
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= shlf_pkg::PH_START;
            prev_cr_reg    <= 1'b0;
            line_begin_reg <= 1'b1;
            offset_reg     <= '0;
            line_start_reg <= '0;
            pend_start_reg <= '0;
            pend_len_reg   <= '0;
            pend_valid_reg <= 1'b0;
            seen_reg       <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            prev_cr_reg    <= prev_cr_next;
            line_begin_reg <= line_begin_next;
            offset_reg     <= offset_next;
            line_start_reg <= line_start_next;
            pend_start_reg <= pend_start_next;
            pend_len_reg   <= pend_len_next;
            pend_valid_reg <= pend_valid_next;
            seen_reg       <= seen_next;
        end
    end

endmodule

FILE: rtl/shlf_queue.sv
// shlf_queue.sv: small result queue, takes up to two results a cycle, gives one
// depends on shlf_pkg; fed by shlf_step
module shlf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  shlf_pkg::push_t   push,
    output logic              room,
    output logic              result_valid,
    input  logic              result_ready,
    output shlf_pkg::result_t result
);

    shlf_pkg::result_t              q_reg [shlf_pkg::QUEUE_DEPTH];
    logic [shlf_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [shlf_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [shlf_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           pop;

    // room for the largest run of one byte
    assign room         = (count_reg <= shlf_pkg::QCNT_W'(shlf_pkg::QUEUE_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result       = q_reg[rd_ptr_reg];
    assign pop          = result_valid && result_ready;

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + shlf_pkg::QUEUE_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + shlf_pkg::QUEUE_AW'(pop);
        count_next  = count_reg + shlf_pkg::QCNT_W'(push.count) - shlf_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry writes
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wr_ptr_reg + shlf_pkg::QUEUE_AW'(1)] <= push.second;
        end
    end

endmodule

FILE: verif/sip_header_line_framer_test.sv
// sip_header_line_framer_test: self-checking bench for the sip header line framer
// streams directed, random and long sip messages through the block and checks every result
// depends on shlf_pkg and the sip_header_line_framer rtl
`timescale 1ns / 100ps

module sip_header_line_framer_test;

    localparam int MAX_BYTES    = shlf_pkg::MAX_BYTES_DEFAULT;
    localparam int HDR_LIMIT    = shlf_pkg::HDR_LIMIT_DEFAULT;
    localparam int RANDOM_BYTES = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 500000;

    // byte positions reach MAX_BYTES itself, so one bit wider than the ports
    typedef logic [12:0] pos_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    shlf_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    shlf_pkg::result_t result;

    shlf_pkg::item_t   pending_items[$];
    shlf_pkg::result_t framed_lines_due[$];
    logic [7:0]        msg_bytes[$];

    int  short_total;
    int  bytes_sent;
    int  messages_built;
    int  results_seen;
    int  mismatch_count;
    int  cycle_count;
    logic sink_paused = 1'b0;

    // framer state mirrored by the checker
    shlf_pkg::phase_t fr_phase;
    logic             prev_cr;
    logic             line_begin;
    pos_t             byte_pos;
    pos_t             line_start;
    pos_t             hdr_start;
    pos_t             hdr_len;
    logic             hdr_pending;
    int unsigned      hdr_count;

    sip_header_line_framer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic clear_framer();
        fr_phase    = shlf_pkg::PH_START;
        prev_cr     = 1'b0;
        line_begin  = 1'b1;
        byte_pos    = '0;
        line_start  = '0;
        hdr_start   = '0;
        hdr_len     = '0;
        hdr_pending = 1'b0;
        hdr_count   = 0;
    endtask

    function automatic shlf_pkg::result_t make_line(input shlf_pkg::kind_t kind,
                                                    input pos_t off, input pos_t len);
        shlf_pkg::result_t r;
        r.result_kind  = kind;
        r.line_offset  = off[11:0];
        r.line_length  = len[11:0];
        r.header_index = (hdr_count > 255) ? 8'd255 : hdr_count[7:0];
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic string show_line(input shlf_pkg::result_t r);
        return $sformatf("kind %0d offset %0d length %0d index %0d last %0b",
                         r.result_kind, r.line_offset, r.line_length,
                         r.header_index, r.last_of_run);
    endfunction

    // expected results of one accepted byte, appended in order
    task automatic frame_byte(input shlf_pkg::item_t it);
        shlf_pkg::result_t step_lines[$];
        pos_t              o;
        pos_t              len;
        if (fr_phase == shlf_pkg::PH_START || fr_phase == shlf_pkg::PH_HEADERS)
        begin
            if (byte_pos >= MAX_BYTES)
            begin
                step_lines.push_back(make_line(shlf_pkg::KIND_TOO_LONG, line_start, '0));
                fr_phase = shlf_pkg::PH_STOPPED;
            end
            else
            begin
                o = byte_pos;
                byte_pos = pos_t'(o + 1);
                // a held header is released once the next line is not a continuation
                if (fr_phase == shlf_pkg::PH_HEADERS && line_begin && hdr_pending &&
                    it.data_byte != shlf_pkg::CHAR_SP && it.data_byte != shlf_pkg::CHAR_TAB)
                begin
                    step_lines.push_back(make_line(shlf_pkg::KIND_HEADER, hdr_start, hdr_len));
                    if (hdr_count < HDR_LIMIT)
                        hdr_count++;
                    hdr_pending = 1'b0;
                end
                line_begin = 1'b0;
                if (prev_cr && it.data_byte == shlf_pkg::CHAR_LF)
                begin
                    // the cr at o-1 belongs to the line just ended
                    len = pos_t'(o - 1 - line_start);
                    if (fr_phase == shlf_pkg::PH_START)
                    begin
                        if (len == 0)
                        begin
                            step_lines.push_back(make_line(shlf_pkg::KIND_BAD_START,
                                                           line_start, '0));
                            fr_phase = shlf_pkg::PH_STOPPED;
                        end
                        else
                        begin
                            step_lines.push_back(make_line(shlf_pkg::KIND_START,
                                                           line_start, len));
                            fr_phase = shlf_pkg::PH_HEADERS;
                        end
                    end
                    else if (len == 0)
                    begin
                        if (hdr_count == 0)
                        begin
                            step_lines.push_back(make_line(shlf_pkg::KIND_NO_HEADERS,
                                                           line_start, '0));
                            fr_phase = shlf_pkg::PH_STOPPED;
                        end
                        else
                        begin
                            step_lines.push_back(make_line(shlf_pkg::KIND_END,
                                                           pos_t'(o + 1), '0));
                            fr_phase = shlf_pkg::PH_BODY;
                        end
                    end
                    else if (hdr_pending)
                        hdr_len = pos_t'(o - 1 - hdr_start);
                    else
                    begin
                        hdr_start   = line_start;
                        hdr_len     = len;
                        hdr_pending = 1'b1;
                    end
                    line_start = pos_t'(o + 1);
                    line_begin = 1'b1;
                    prev_cr    = 1'b0;
                end
                else
                    prev_cr = (it.data_byte == shlf_pkg::CHAR_CR);
            end
            if (it.is_last &&
                (fr_phase == shlf_pkg::PH_START || fr_phase == shlf_pkg::PH_HEADERS))
                step_lines.push_back(make_line(shlf_pkg::KIND_TRUNCATED, line_start,
                                               byte_pos - line_start));
        end
        foreach (step_lines[i])
        begin
            if (i == step_lines.size() - 1)
                step_lines[i].last_of_run = 1'b1;
            framed_lines_due.push_back(step_lines[i]);
        end
        if (it.is_last)
            clear_framer();
    endtask

    // message building
    task automatic push_byte(input logic [7:0] b);
        msg_bytes.push_back(b);
    endtask

    task automatic add_crlf();
        msg_bytes.push_back(shlf_pkg::CHAR_CR);
        msg_bytes.push_back(shlf_pkg::CHAR_LF);
    endtask

    task automatic add_fill(input int n);
        repeat (n)
            msg_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endtask

    // mostly printable, sometimes any byte or a stray cr
    task automatic add_content(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                msg_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
            else if (pick < 95)
                msg_bytes.push_back(8'($urandom_range(0, 255)));
            else
                msg_bytes.push_back(shlf_pkg::CHAR_CR);
        end
    endtask

    task automatic send_message();
        shlf_pkg::item_t it;
        foreach (msg_bytes[i])
        begin
            it.data_byte = msg_bytes[i];
            it.is_last   = (i == msg_bytes.size() - 1);
            pending_items.push_back(it);
        end
        msg_bytes.delete();
        messages_built++;
    endtask

    task automatic make_random_message();
        int n_hdr;
        int cut;
        int pick;
        if ($urandom_range(0, 99) < 20)
        begin
            // noise rich in line-end and fold characters
            repeat ($urandom_range(1, 40))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    push_byte(shlf_pkg::CHAR_CR);
                else if (pick < 4)
                    push_byte(shlf_pkg::CHAR_LF);
                else if (pick == 4)
                    push_byte(shlf_pkg::CHAR_SP);
                else if (pick == 5)
                    push_byte(shlf_pkg::CHAR_TAB);
                else
                    push_byte(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            add_content(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12));
            add_crlf();
            n_hdr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            repeat (n_hdr)
            begin
                add_fill(1);
                add_content($urandom_range(0, 9));
                add_crlf();
                // folded continuation lines
                if ($urandom_range(0, 99) < 30)
                    repeat ($urandom_range(1, 2))
                    begin
                        push_byte($urandom_range(0, 1) ? shlf_pkg::CHAR_SP : shlf_pkg::CHAR_TAB);
                        add_content($urandom_range(0, 6));
                        add_crlf();
                    end
            end
            add_crlf();
            repeat ($urandom_range(0, 8))
                push_byte(8'($urandom_range(0, 255)));
            // cut short somewhere
            if ($urandom_range(0, 99) < 15)
            begin
                cut = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > cut)
                    void'(msg_bytes.pop_back());
            end
        end
        send_message();
    endtask

    // idle rates follow the progress through the short messages
    function automatic int source_idle_pct();
        if (bytes_sent < short_total / 3)
            return 19;
        else if (bytes_sent < 2 * short_total / 3)
            return 60;
        return 0;
    endfunction

    function automatic int sink_idle_pct();
        if (bytes_sent < short_total / 3)
            return 60;
        else if (bytes_sent < 2 * short_total / 3)
            return 19;
        return 0;
    endfunction

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                frame_byte(item);
                bytes_sent++;
            end
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= source_idle_pct())
                begin
                    item_valid <= 1'b1;
                    item       <= pending_items.pop_front();
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result ready, with random stalls and the long pause
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !sink_paused && ($urandom_range(0, 99) >= sink_idle_pct());
    end

    // long receiver pause while bytes keep coming, so the result queue fills
    initial
    begin
        do
            @(posedge clk);
        while (bytes_sent < short_total * 5 / 6);
        sink_paused <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        sink_paused <= 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin : result_check
        shlf_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (framed_lines_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result: %s", $realtime, show_line(result));
            end
            else
            begin
                want = framed_lines_due.pop_front();
                if (result.result_kind !== want.result_kind ||
                    result.line_offset !== want.line_offset ||
                    result.line_length !== want.line_length ||
                    result.header_index !== want.header_index ||
                    result.last_of_run !== want.last_of_run)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result %0d wrong\n  expected %s\n  actual   %s",
                                 $realtime, results_seen, show_line(want), show_line(result));
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes left, %0d results outstanding",
                     cycle_count, pending_items.size(), framed_lines_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        clear_framer();

        // empty start line
        push_byte(shlf_pkg::CHAR_CR);
        push_byte(shlf_pkg::CHAR_LF);
        send_message();
        // blank line right after the start line
        push_byte(8'h41);
        add_crlf();
        add_crlf();
        send_message();
        // extreme bytes, folded header, headers end, ignored body
        push_byte(8'hFF);
        add_crlf();
        push_byte(8'h00);
        add_crlf();
        push_byte(shlf_pkg::CHAR_SP);
        push_byte(shlf_pkg::CHAR_TAB);
        add_crlf();
        add_crlf();
        push_byte(8'h80);
        send_message();
        // cut short on the byte that releases a header
        push_byte(8'h41);
        add_crlf();
        push_byte(8'h42);
        add_crlf();
        push_byte(8'h43);
        send_message();

        while (pending_items.size() < RANDOM_BYTES)
            make_random_message();
        short_total = pending_items.size();

        // header count saturation
        push_byte(8'h53);
        add_crlf();
        repeat (HDR_LIMIT + 5)
        begin
            add_fill(1);
            add_crlf();
        end
        add_crlf();
        send_message();

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_valid || framed_lines_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("framed %0d bytes in %0d messages (%0d in short random ones)",
                 bytes_sent, messages_built, short_total);
        $display("checked %0d results, %0d errors, %0d cycles",
                 results_seen, mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
